// ----- hw/rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console character writer
// Default geometry, character codes, command and register codes, and the
// control structures passed between the core and the cursor unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 25;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_PRINT_LOW = 8'h20;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Register select, taken from bit 2 of the byte address.
   localparam logic REG_TEXT_COLOR = 1'b0;
   localparam logic REG_BACK_COLOR = 1'b1;

   localparam logic [3:0] TEXT_COLOR_RESET = 4'd2;
   localparam logic [3:0] BACK_COLOR_RESET = 4'd0;

   // Cursor operations requested by the core.
   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_NEWLINE = 2'd1;
   localparam logic [1:0] OP_RETURN  = 2'd2;
   localparam logic [1:0] OP_PRINT   = 2'd3;

   typedef struct packed {
      logic       commit;
      logic [1:0] op;
   } cur_ctl_type;

   typedef struct packed {
      logic scroll;
   } cur_stat_type;

endpackage

// ----- hw/rtl/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor: cursor tracking unit
// Holds the linear cursor with its column and row start, plans the move for
// the pending operation and applies it on commit.
// ----------------------------------------------------------------------------
module tcw_cursor #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
   localparam int CELLS = COLS * ROWS,
   localparam int CW = $clog2(CELLS + 1),
   localparam int AW = $clog2(CELLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::cur_ctl_type  ctl,
   output tcw_pkg::cur_stat_type stat,
   output logic [CW-1:0]         cursor,
   output logic [AW-1:0]         wr_addr
);
   import tcw_pkg::*;

   localparam int COLW = $clog2(COLS);

   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [CW-1:0]   base_ff, base_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [CW:0]     nl_sum;
   logic            nl_over;
   logic            at_end;
   logic            scroll;

   assign nl_sum  = {1'b0, cursor_ff} + (CW + 1)'(COLS);
   assign nl_over = nl_sum > (CW + 1)'(CELLS);
   assign at_end  = cursor_ff == CW'(CELLS);

   always_comb begin
      cursor_in = cursor_ff;
      base_in   = base_ff;
      col_in    = col_ff;
      scroll    = 1'b0;
      wr_addr   = cursor_ff[AW-1:0];
      case (ctl.op)
         OP_NEWLINE: begin
            scroll = nl_over;
            if (!nl_over) begin
               base_in = base_ff + CW'(COLS);
            end
            cursor_in = base_in;
            col_in    = '0;
         end
         OP_RETURN: begin
            cursor_in = base_ff;
            col_in    = '0;
         end
         OP_PRINT: begin
            if (at_end) begin
               // The last row is vacated by the scroll; write its first cell.
               scroll    = 1'b1;
               wr_addr   = AW'(CELLS - COLS);
               base_in   = CW'(CELLS - COLS);
               cursor_in = CW'(CELLS - COLS + 1);
               col_in    = COLW'(1);
            end else begin
               cursor_in = cursor_ff + CW'(1);
               if (col_ff == COLW'(COLS - 1)) begin
                  col_in  = '0;
                  base_in = base_ff + CW'(COLS);
               end else begin
                  col_in = col_ff + COLW'(1);
               end
            end
         end
         default: begin
            scroll = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         base_ff   <= '0;
         col_ff    <= '0;
      end else if (ctl.commit) begin
         cursor_ff <= cursor_in;
         base_ff   <= base_in;
         col_ff    <= col_in;
      end
   end

   assign stat.scroll = scroll;
   assign cursor      = cursor_ff;

   // The cursor never passes the screen end.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CW'(CELLS))
      else $error("cursor past screen end");

   // Row start plus column always gives the linear cursor.
   a_cursor_split: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == base_ff + CW'(col_ff))
      else $error("cursor split inconsistent");

   // The column stays inside one row.
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COLW'(COLS - 1))
      else $error("column past row end");

endmodule

// ----- hw/rtl/text_console_char_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_core: text-mode console writer with scroll
// Cell store in one synchronous memory, a cursor unit, a scroll and clear
// sweep, an APB-style color register port and a registered result stage.
// ----------------------------------------------------------------------------
// A read passes through the exec and output states; a put goes through the
// exec, final and output states. A new request is taken only once the previous
// result has entered the output stage. A put that scrolls first runs the row
// move sweep, which copies one cell per cycle through the memory read and write ports.
// Reset is synchronous; afterwards a clearing sweep zeroes the memory while
// no request is taken.
module text_console_char_writer_core #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_char_byte,
   input  logic [10:0] req_cell_index,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_cell_value,
   output logic [10:0] rsp_cursor_pos,
   output logic        rsp_scrolled,
   output logic        rsp_wrote_cell,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tcw_pkg::*;

   localparam int CELLS    = COLS * ROWS;
   localparam int CW       = $clog2(CELLS + 1);
   localparam int AW       = $clog2(CELLS);
   localparam int XW       = CW + 11;
   localparam int COPY_END = CELLS - COLS;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   // ---------------------------------------------------------------------
   // Color registers. Writes decode only bit 2 of the address, so both
   // registers are visible at every byte of their word.
   // ---------------------------------------------------------------------
   logic [3:0] text_color_ff;
   logic [3:0] back_color_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RESET;
         back_color_ff <= BACK_COLOR_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_TEXT_COLOR) begin
            text_color_ff <= csr_pwdata[3:0];
         end else begin
            back_color_ff <= csr_pwdata[3:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_TEXT_COLOR: csr_prdata[3:0] = text_color_ff;
         REG_BACK_COLOR: csr_prdata[3:0] = back_color_ff;
         default:        csr_prdata      = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control and latched request.
   // ---------------------------------------------------------------------
   logic [2:0]  state_ff, state_in;
   logic        op_cmd_ff;
   logic [7:0]  op_char_ff;
   logic [10:0] op_idx_ff;
   logic        req_accept;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_cmd_ff  <= req_command;
         op_char_ff <= req_char_byte;
         op_idx_ff  <= req_cell_index;
      end
   end

   // Decode the latched byte into a cursor operation.
   logic [1:0] put_op;
   logic       is_print;

   assign is_print = !op_char_ff[7] && (op_char_ff >= CHAR_PRINT_LOW);

   always_comb begin
      if (op_char_ff == CHAR_NEWLINE) begin
         put_op = OP_NEWLINE;
      end else if (op_char_ff == CHAR_RETURN) begin
         put_op = OP_RETURN;
      end else if (is_print) begin
         put_op = OP_PRINT;
      end else begin
         put_op = OP_NONE;
      end
   end

   // ---------------------------------------------------------------------
   // Cursor unit. It plans from the committed cursor, so the plan stays put
   // across a scroll sweep and is committed only at the final step.
   // ---------------------------------------------------------------------
   cur_ctl_type   cur_ctl;
   cur_stat_type  cur_stat;
   logic [CW-1:0] cur_pos;
   logic [AW-1:0] cur_wr_addr;

   tcw_cursor #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_cursor (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cur_ctl),
      .stat    (cur_stat),
      .cursor  (cur_pos),
      .wr_addr (cur_wr_addr)
   );

   // Read command address and range check.
   logic [XW-1:0] idx_ext;
   logic          idx_in_range;

   assign idx_ext      = XW'(op_idx_ff);
   assign idx_in_range = idx_ext < XW'(CELLS);

   // ---------------------------------------------------------------------
   // Cell memory: one write port and one registered read port.
   // ---------------------------------------------------------------------
   logic [15:0]   cell_mem [CELLS];
   logic [15:0]   mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= cell_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // Sweep: walks every cell once. In copy mode a cell takes the value one
   // row below it, and the last row is zeroed; in clear mode all cells are
   // zeroed. Reads run in the cycle before the matching write.
   // ---------------------------------------------------------------------
   logic          sw_busy_ff, sw_busy_in;
   logic          sw_copy_ff, sw_copy_in;
   logic [AW-1:0] sw_ptr_ff, sw_ptr_in;
   logic          wr_pend_ff, wr_pend_in;
   logic          wr_zero_ff, wr_zero_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          sw_copy_now;
   logic          sw_done;

   assign sw_copy_now = sw_copy_ff && (sw_ptr_ff < AW'(COPY_END));
   assign sw_done     = !sw_busy_ff && !wr_pend_ff;

   // Result holding registers and the output stage.
   logic [15:0] res_value_ff, res_value_in;
   logic        res_mem_ff, res_mem_in;
   logic        res_hit_ff, res_hit_in;
   logic        res_scrolled_ff, res_scrolled_in;
   logic        res_wrote_ff, res_wrote_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_cell_value_ff, rsp_cell_value_in;
   logic [10:0]   rsp_cursor_pos_ff, rsp_cursor_pos_in;
   logic          rsp_scrolled_ff, rsp_scrolled_in;
   logic          rsp_wrote_cell_ff, rsp_wrote_cell_in;
   logic          rsp_free;
   logic          rsp_load;
   logic [XW-1:0] cur_pos_ext;
   logic [15:0]   put_cell;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign cur_pos_ext = XW'(cur_pos);
   assign put_cell    = {back_color_ff, text_color_ff, op_char_ff};

   always_comb begin
      state_in        = state_ff;
      sw_busy_in      = sw_busy_ff;
      sw_copy_in      = sw_copy_ff;
      sw_ptr_in       = sw_ptr_ff;
      wr_pend_in      = 1'b0;
      wr_zero_in      = wr_zero_ff;
      wr_addr_in      = wr_addr_ff;
      res_value_in    = res_value_ff;
      res_mem_in      = res_mem_ff;
      res_hit_in      = res_hit_ff;
      res_scrolled_in = res_scrolled_ff;
      res_wrote_in    = res_wrote_ff;
      cur_ctl.commit  = 1'b0;
      cur_ctl.op      = put_op;
      mem_we          = 1'b0;
      mem_waddr       = wr_addr_ff;
      mem_wdata       = wr_zero_ff ? 16'h0000 : mem_q_ff;
      mem_re          = 1'b0;
      mem_raddr       = AW'(sw_ptr_ff + AW'(COLS));
      rsp_load        = 1'b0;

      // Sweep engine, active only in the clear and scroll states.
      if ((state_ff == S_CLEAR) || (state_ff == S_SCROLL)) begin
         if (sw_busy_ff) begin
            mem_re     = sw_copy_now;
            wr_pend_in = 1'b1;
            wr_addr_in = sw_ptr_ff;
            wr_zero_in = !sw_copy_now;
            sw_ptr_in  = sw_ptr_ff + AW'(1);
            if (sw_ptr_ff == AW'(CELLS - 1)) begin
               sw_busy_in = 1'b0;
            end
         end
         if (wr_pend_ff) begin
            mem_we = 1'b1;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            if (sw_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_cmd_ff == CMD_READ) begin
               mem_re          = idx_in_range;
               mem_raddr       = idx_ext[AW-1:0];
               res_mem_in      = 1'b1;
               res_hit_in      = idx_in_range;
               res_scrolled_in = 1'b0;
               res_wrote_in    = 1'b0;
               state_in        = S_OUT;
            end else if (cur_stat.scroll) begin
               sw_busy_in = 1'b1;
               sw_copy_in = 1'b1;
               sw_ptr_in  = '0;
               state_in   = S_SCROLL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SCROLL: begin
            if (sw_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cur_ctl.commit  = 1'b1;
            mem_we          = is_print;
            mem_waddr       = cur_wr_addr;
            mem_wdata       = put_cell;
            res_mem_in      = 1'b0;
            res_value_in    = is_print ? put_cell : 16'h0000;
            res_scrolled_in = cur_stat.scroll;
            res_wrote_in    = is_print;
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output stage: takes a new result once the previous one has been taken.
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_cell_value_in = rsp_cell_value_ff;
      rsp_cursor_pos_in = rsp_cursor_pos_ff;
      rsp_scrolled_in   = rsp_scrolled_ff;
      rsp_wrote_cell_in = rsp_wrote_cell_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (res_mem_ff) begin
            rsp_cell_value_in = res_hit_ff ? mem_q_ff : 16'h0000;
         end else begin
            rsp_cell_value_in = res_value_ff;
         end
         rsp_cursor_pos_in = cur_pos_ext[10:0];
         rsp_scrolled_in   = res_scrolled_ff;
         rsp_wrote_cell_in = res_wrote_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sw_busy_ff   <= 1'b1;
         sw_copy_ff   <= 1'b0;
         sw_ptr_ff    <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_busy_ff   <= sw_busy_in;
         sw_copy_ff   <= sw_copy_in;
         sw_ptr_ff    <= sw_ptr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_zero_ff        <= wr_zero_in;
      wr_addr_ff        <= wr_addr_in;
      res_value_ff      <= res_value_in;
      res_mem_ff        <= res_mem_in;
      res_hit_ff        <= res_hit_in;
      res_scrolled_ff   <= res_scrolled_in;
      res_wrote_ff      <= res_wrote_in;
      rsp_cell_value_ff <= rsp_cell_value_in;
      rsp_cursor_pos_ff <= rsp_cursor_pos_in;
      rsp_scrolled_ff   <= rsp_scrolled_in;
      rsp_wrote_cell_ff <= rsp_wrote_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_value_ff;
   assign rsp_cursor_pos = rsp_cursor_pos_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_wrote_cell = rsp_wrote_cell_ff;

   // A new result never overwrites one that is still waiting to be taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before transaction completed");

   // The sweep never reads the cell it is writing in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("memory read and write collide");

   // The memory is never written while waiting for a new transaction.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!mem_we && !sw_busy_ff))
      else $error("memory activity while idle");

   // A scrolled result always comes from a put that went through the sweep.
   a_scroll_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && cur_stat.scroll) |-> $past(state_ff == S_SCROLL))
      else $error("scroll committed without sweep");

endmodule

// ----- tb/text_console_char_writer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_writer_core_tb: self-checking bench for the console writer
// Drives put and read transactions with random idling on both channels,
// predicts untyped responses from a private copy of the screen, the cursor and
// the color registers, and sweeps the color registers between phases.
// ----------------------------------------------------------------------------
module text_console_char_writer_core_tb;
   import tcw_pkg::*;

   localparam int COLS = COLS_DEFAULT;
   localparam int ROWS = ROWS_DEFAULT;
   localparam int CELLS = COLS * ROWS;
   localparam logic [7:0] CHAR_PRINT_HIGH = 8'h7F;
   localparam int IDLE_PCT = 28;
   localparam int RANDOM_ITEMS = 1050;
   localparam int PHASES = 7;
   localparam int REPORT_LIMIT = 10;
   localparam int DIRECTED_ROWS = 22;

   // One response transaction, in port order.
   typedef struct packed {
      logic [15:0] cell_value;
      logic [10:0] cursor_pos;
      logic        scrolled;
      logic        wrote_cell;
   } cell_reply_type;

   // A row of the directed table. A typed row carries its response written
   // out by hand; the others are checked against the screen predictor.
   typedef struct {
      logic           command;
      logic [7:0]     char_byte;
      logic [10:0]    cell_index;
      int             repeats;
      bit             typed;
      cell_reply_type reply;
   } console_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_PUT;
   logic [7:0]  req_char_byte = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_cell_value;
   logic [10:0] rsp_cursor_pos;
   logic        rsp_scrolled;
   logic        rsp_wrote_cell;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // When set, neither side idles, so the block runs at its own pace.
   bit quiet = 1'b0;
   int fault_count = 0;

   // Predicted screen contents, cursor and color registers.
   logic [15:0] screen [CELLS];
   int          cursor_cells;
   logic [3:0]  fg_color;
   logic [3:0]  bg_color;

   // Responses still owed by the block, oldest first.
   cell_reply_type reply_queue [$];

   text_console_char_writer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_char_byte  (req_char_byte),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_wrote_cell (rsp_wrote_cell),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #10 clock = ~clock;

   // Directed table. It starts right after reset with the reset colors, so
   // every typed cell carries foreground 2 and background 0. The run of
   // newlines takes the cursor to the last row; the next newline parks it
   // exactly at the screen end without scrolling, and only the following
   // printable character scrolls the screen.
   console_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_READ, 8'h00, 11'd0,    1,  1'b1, '{16'h0000, 11'd0,    1'b0, 1'b0}},
      '{CMD_READ, 8'h00, 11'd2047, 1,  1'b1, '{16'h0000, 11'd0,    1'b0, 1'b0}},
      '{CMD_READ, 8'h00, 11'd1999, 1,  1'b1, '{16'h0000, 11'd0,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h20, 11'd0,    1,  1'b1, '{16'h0220, 11'd1,    1'b0, 1'b1}},
      '{CMD_PUT,  8'h7F, 11'd0,    1,  1'b1, '{16'h027F, 11'd2,    1'b0, 1'b1}},
      '{CMD_PUT,  8'h1F, 11'd0,    1,  1'b1, '{16'h0000, 11'd2,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h80, 11'd0,    1,  1'b1, '{16'h0000, 11'd2,    1'b0, 1'b0}},
      '{CMD_PUT,  8'hFF, 11'd2047, 1,  1'b1, '{16'h0000, 11'd2,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h00, 11'd0,    1,  1'b1, '{16'h0000, 11'd2,    1'b0, 1'b0}},
      '{CMD_READ, 8'hFF, 11'd1,    1,  1'b1, '{16'h027F, 11'd2,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h0D, 11'd0,    1,  1'b1, '{16'h0000, 11'd0,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h41, 11'd2047, 1,  1'b1, '{16'h0241, 11'd1,    1'b0, 1'b1}},
      '{CMD_PUT,  8'h0A, 11'd0,    1,  1'b1, '{16'h0000, 11'd80,   1'b0, 1'b0}},
      '{CMD_READ, 8'hFF, 11'd0,    1,  1'b1, '{16'h0241, 11'd80,   1'b0, 1'b0}},
      '{CMD_PUT,  8'h0A, 11'd0,    23, 1'b0, '{16'h0000, 11'd0,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h0A, 11'd0,    1,  1'b1, '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      '{CMD_PUT,  8'h0D, 11'd0,    1,  1'b1, '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      '{CMD_READ, 8'h00, 11'd2000, 1,  1'b1, '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      '{CMD_PUT,  8'h5A, 11'd0,    1,  1'b1, '{16'h025A, 11'd1921, 1'b1, 1'b1}},
      '{CMD_READ, 8'h00, 11'd1920, 1,  1'b1, '{16'h025A, 11'd1921, 1'b0, 1'b0}},
      '{CMD_READ, 8'h00, 11'd0,    1,  1'b0, '{16'h0000, 11'd0,    1'b0, 1'b0}},
      '{CMD_PUT,  8'h0A, 11'd0,    1,  1'b1, '{16'h0000, 11'd1920, 1'b1, 1'b0}}
   };

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         screen[i] = '0;
      end
      cursor_cells = 0;
      fg_color = TEXT_COLOR_RESET;
      bg_color = BACK_COLOR_RESET;
   end

   // Counts a failure and tells whether it is still among the reported ones.
   function automatic bit report_fault();
      fault_count++;
      return fault_count <= REPORT_LIMIT;
   endfunction

   // Moves every row up by one and blanks the bottom row.
   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) begin
         screen[i] = screen[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
         screen[i] = '0;
      end
   endfunction

   // Applies one accepted request to the predicted screen and returns the
   // response that the block owes for it.
   function automatic cell_reply_type console_step(logic command, logic [7:0] ch,
                                                   logic [10:0] idx);
      cell_reply_type r;
      r = '0;
      if (command == CMD_READ) begin
         // Reads past the last cell return zero.
         if (idx < CELLS) begin
            r.cell_value = screen[idx];
         end
      end else if (ch == CHAR_NEWLINE) begin
         cursor_cells += COLS;
         if (cursor_cells > CELLS) begin
            scroll_screen();
            cursor_cells -= COLS;
            r.scrolled = 1'b1;
         end
         cursor_cells -= cursor_cells % COLS;
      end else if (ch == CHAR_RETURN) begin
         cursor_cells -= cursor_cells % COLS;
      end else if (ch >= CHAR_PRINT_LOW && ch <= CHAR_PRINT_HIGH) begin
         // The cursor may rest at the screen end; the scroll happens only
         // when a later character would go past it.
         cursor_cells++;
         if (cursor_cells > CELLS) begin
            scroll_screen();
            cursor_cells -= COLS;
            r.scrolled = 1'b1;
         end
         r.cell_value = {bg_color, fg_color, ch};
         screen[cursor_cells - 1] = r.cell_value;
         r.wrote_cell = 1'b1;
      end
      // Any other byte leaves the state alone and gives an empty response.
      r.cursor_pos = cursor_cells[10:0];
      return r;
   endfunction

   // Presents one request transaction, optionally after some idle cycles, and
   // records its response once the block has taken it. The task is entered
   // and left on a rising edge, so valid stays high between back-to-back
   // transactions and only the payload changes.
   task automatic send_request(logic command, logic [7:0] ch, logic [10:0] idx,
                               bit typed, cell_reply_type typed_reply);
      cell_reply_type predicted;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while (!quiet && $urandom_range(99) < IDLE_PCT);
      end
      req_valid      <= 1'b1;
      req_command    <= command;
      req_char_byte  <= ch;
      req_cell_index <= idx;
      do begin
         @(posedge clock);
      end while (req_stall);
      predicted = console_step(command, ch, idx);
      reply_queue.push_back(typed ? typed_reply : predicted);
   endtask

   // Writes one color register, then reads it back. Only the low nibble is
   // meaningful, so the upper write data bits are random.
   task automatic set_color(logic sel, logic [3:0] value);
      logic [31:0] wdata;
      wdata = {$urandom()};
      wdata[3:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (sel == REG_TEXT_COLOR) begin
         fg_color = value;
      end else begin
         bg_color = value;
      end
      // Back-to-back read of the same register.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (csr_prdata[3:0] !== value) begin
         if (report_fault()) begin
            $display("color register %0d read back %h, expected %h at %0t",
                     sel, csr_prdata[3:0], value, $time);
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Stops sending and waits until every outstanding response is in, plus a
   // few cycles of margin, so the block is idle for register writes.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (reply_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // One random transaction. Most puts are printable text with newlines and
   // returns mixed in, which keeps the cursor moving down and scrolling; the
   // rest are reads and arbitrary bytes that the block should ignore.
   task automatic send_random_item();
      int          pick;
      int          lo;
      logic [7:0]  ch;
      logic [10:0] idx;
      pick = $urandom_range(99);
      ch   = 8'($urandom_range(255));
      idx  = 11'($urandom_range(2047));
      if (pick < 26) begin
         case ($urandom_range(2))
            0: begin
               // Just behind the cursor, where text was recently written.
               lo  = (cursor_cells > 160) ? cursor_cells - 160 : 0;
               idx = 11'($urandom_range(cursor_cells, lo));
            end
            1: begin
               // Around the last cell and past the screen end.
               idx = 11'($urandom_range(2047, CELLS - 10));
            end
            default: begin
            end
         endcase
         send_request(CMD_READ, ch, idx, 1'b0, '0);
      end else begin
         if (pick < 80) begin
            ch = 8'($urandom_range(CHAR_PRINT_HIGH, CHAR_PRINT_LOW));
         end else if (pick < 87) begin
            ch = CHAR_NEWLINE;
         end else if (pick < 91) begin
            ch = CHAR_RETURN;
         end
         send_request(CMD_PUT, ch, idx, 1'b0, '0);
      end
   endtask

   // The receiver stalls at random except during the quiet phase.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Response checker: every accepted response transaction is matched against
   // the oldest outstanding prediction.
   always @(posedge clock) begin
      cell_reply_type got;
      cell_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_cell_value, rsp_cursor_pos, rsp_scrolled, rsp_wrote_cell};
         if (reply_queue.size() == 0) begin
            if (report_fault()) begin
               $display("unexpected response at %0t: cell %h cursor %0d", $time,
                        got.cell_value, got.cursor_pos);
            end
         end else begin
            want = reply_queue.pop_front();
            if (got !== want) begin
               if (report_fault()) begin
                  $display("response mismatch at %0t", $time);
                  $display("  expected cell %h cursor %0d scrolled %b wrote %b",
                           want.cell_value, want.cursor_pos, want.scrolled,
                           want.wrote_cell);
                  $display("  actual   cell %h cursor %0d scrolled %b wrote %b",
                           got.cell_value, got.cursor_pos, got.scrolled,
                           got.wrote_cell);
               end
            end
         end
      end
   end

   // Main sequence: reset, the directed table with reset colors, then random
   // phases, each under its own pair of colors. Phase 3 runs with no idling.
   initial begin
      logic [3:0] text_value;
      logic [3:0] back_value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The first request waits out the clearing sweep through req_stall.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         for (int n = 0; n < directed_rows[row].repeats; n++) begin
            send_request(directed_rows[row].command, directed_rows[row].char_byte,
                         directed_rows[row].cell_index, directed_rows[row].typed,
                         directed_rows[row].reply);
         end
      end
      drain_replies();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               text_value = 4'hF;
               back_value = 4'hF;
            end
            1: begin
               text_value = 4'h0;
               back_value = 4'h0;
            end
            2: begin
               text_value = 4'hF;
               back_value = 4'h0;
            end
            3: begin
               text_value = 4'h0;
               back_value = 4'hF;
            end
            default: begin
               text_value = 4'($urandom_range(15));
               back_value = 4'($urandom_range(15));
            end
         endcase
         set_color(REG_TEXT_COLOR, text_value);
         set_color(REG_BACK_COLOR, back_value);
         quiet = (phase == 3);
         repeat (RANDOM_ITEMS / PHASES) send_random_item();
         drain_replies();
      end
      quiet = 1'b0;

      if (fault_count == 0 && reply_queue.size() == 0) begin
         $display("text_console_char_writer_core test passed");
      end else begin
         $display("text_console_char_writer_core test failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run even if every put scrolled.
   initial begin
      #200_000_000;
      $display("text_console_char_writer_core test failed");
      $finish;
   end

endmodule
